@@ hdl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int PRIO_W = 16;
  localparam int PAYLOAD_W = 16;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXTRACTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // One queue slot as it travels between neighboring cells.
  typedef struct packed {
    logic                 valid;
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  // Broadcast control that every cell sees in the same cycle.
  typedef struct packed {
    logic                 shift_in;
    logic                 shift_out;
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
  } cell_ctrl_t;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t    left_entry,
  input  logic               left_keep,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               keep
);

  spq_pkg::entry_t entry_next;

  // A valid entry with a strictly smaller number stays ahead of a new one.
  assign keep = entry.valid && (entry.prio < ctrl.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_in) begin
      if (!keep) begin
        if (left_keep) begin
          entry_next.valid = 1'b1;
          entry_next.prio = ctrl.prio;
          entry_next.payload = ctrl.payload;
        end else begin
          entry_next = left_entry;
        end
      end
    end else if (ctrl.shift_out) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.prio <= entry_next.prio;
    entry.payload <= entry_next.payload;
  end

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue built as a chain of cells.
//
// A bounded priority queue of QUEUE_DEPTH entries kept in ascending order of
// priority number, with the head in the first cell. A command is a transfer
// at a rising edge where start is high and busy is low; busy is high only
// while the block comes out of reset, so a command can be given in every
// cycle, back to back with no gap. Exactly one result follows
// each command: done is high for one cycle, the cycle after the transfer,
// and status, head_priority and head_payload are valid only then. The
// receiver cannot stall, so it must capture the result in that cycle. An
// insert places the entry ahead of all entries with an equal or larger
// number, so equal priorities leave newest first; an insert into a full
// queue is refused with the full status. An extract returns the head entry,
// or the empty status with zero fields when nothing is stored. The one-cycle
// rate comes from the cell chain: every cell compares its own priority with
// the new one at once and takes its new contents from itself, its left
// neighbor, the command, or its right neighbor in the same clock edge.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [spq_pkg::PRIO_W-1:0]    task_priority,
  input  logic [spq_pkg::PAYLOAD_W-1:0] task_payload,
  output logic                          done,
  output logic [spq_pkg::STATUS_W-1:0]  status,
  output logic [spq_pkg::PRIO_W-1:0]    head_priority,
  output logic [spq_pkg::PAYLOAD_W-1:0] head_payload
);

  spq_pkg::entry_t     cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_keep;
  logic [QUEUE_DEPTH-1:0] valid_vec;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     empty_entry;
  logic                accept;
  logic                is_full;
  logic                is_empty;

  assign accept = start && !busy;

  // The chain stays packed toward the head, so the end cells tell fill state.
  assign is_full = cell_entry[QUEUE_DEPTH-1].valid;
  assign is_empty = !cell_entry[0].valid;

  assign ctrl.shift_in = accept && (op == spq_pkg::OP_INSERT) && !is_full;
  assign ctrl.shift_out = accept && (op == spq_pkg::OP_EXTRACT) && !is_empty;
  assign ctrl.prio = task_priority;
  assign ctrl.payload = task_payload;

  assign empty_entry.valid = 1'b0;
  assign empty_entry.prio = '0;
  assign empty_entry.payload = '0;

  // The head cell sees a left neighbor that always stays ahead, and the tail
  // cell pulls in an empty slot when the queue moves toward the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_keep;

    if (i == 0) begin : g_head
      assign left_entry = empty_entry;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = empty_entry;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left_entry (left_entry),
      .left_keep  (left_keep),
      .right_entry(right_entry),
      .entry      (cell_entry[i]),
      .keep       (cell_keep[i])
    );

    assign valid_vec[i] = cell_entry[i].valid;
  end

  // Busy is set while reset clears the cells and drops once reset is released.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
    end
  end

  // Result register: the head is read before the chain moves.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_priority <= '0;
      head_payload <= '0;
      if (op == spq_pkg::OP_INSERT) begin
        status <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
      end else if (is_empty) begin
        status <= spq_pkg::ST_EMPTY;
      end else begin
        status <= spq_pkg::ST_EXTRACTED;
        head_priority <= cell_entry[0].prio;
        head_payload <= cell_entry[0].payload;
      end
    end
  end

`ifndef SYNTH
  // Valid cells always form an unbroken run starting at the head.
  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("queue cells not packed toward the head");

  // Each result follows exactly one transfer.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result without a preceding transfer");

  // A refused insert leaves the queue untouched.
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (op == spq_pkg::OP_INSERT) && is_full |=> $stable(valid_vec))
    else $error("full queue changed on a refused insert");

  // An extract from a nonempty queue drops exactly one entry.
  a_extract_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.shift_out |=> $countones(valid_vec) + 1 == $countones($past(valid_vec)))
    else $error("extract did not remove exactly one entry");
`endif

endmodule
